>>> sv/tmh_pkg.sv
`timescale 1ns / 1ps

package tmh_pkg;

    localparam int CAP_DEF     = 32;
    localparam int CAP_MAX     = 64;
    localparam int MAX_RESULTS = 32;

    localparam int EXP_W  = 32;
    localparam int HDL_W  = 16;
    localparam int FUNC_W = 2;
    localparam int KIND_W = 3;
    // wide enough for any heap index, count or path at the largest capacity
    localparam int IDX_W  = $clog2(CAP_MAX + 1);
    localparam int LVL_W  = $clog2(IDX_W);

    localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP  = 2'd2;

    localparam logic [KIND_W-1:0] K_ADDED  = 3'd0;
    localparam logic [KIND_W-1:0] K_FULL   = 3'd1;
    localparam logic [KIND_W-1:0] K_FIRED  = 3'd2;
    localparam logic [KIND_W-1:0] K_POPPED = 3'd3;
    localparam logic [KIND_W-1:0] K_NONE   = 3'd4;

    typedef struct packed {
        logic [EXP_W-1:0] exp;
        logic [HDL_W-1:0] hdl;
    } t_entry;

    // one RAM row holds a pair of siblings
    typedef t_entry [1:0] t_row;
    localparam int ROW_W = $bits(t_row);

    typedef enum logic {
        OP_SIFT,
        OP_INS
    } t_op;

    // walker handed from level to level
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [IDX_W-1:0] j;       // index of the node within the level above
        t_entry           ent;     // entry being placed / carried
        logic             placed;  // insert: new entry already dropped into the path
    } t_tok;

    // write of a node in the level above
    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_wb;

    typedef struct packed {
        logic [IDX_W-1:0] count;  // entries held during the walk
        logic [IDX_W-1:0] npath;  // insert: 1-based index of the new slot
        logic [LVL_W-1:0] tdep;   // insert: level of the new slot
    } t_ctx;

    // floor(log2(v)) for v >= 1
    function automatic logic [LVL_W-1:0] lvl_of(input logic [IDX_W-1:0] v);
        logic [LVL_W-1:0] l;
        l = '0;
        for (int b = 0; b < IDX_W; b++) begin
            if (v[b]) begin
                l = LVL_W'(b);
            end
        end
        return l;
    endfunction

endpackage

>>> sv/timer_min_heap_core.sv
`timescale 1ns / 1ps
// Timer queue as a binary min-heap, one cell (pair RAM) per heap level below the root.
// Add to an empty heap sets the root; else the new entry walks down to its new slot.
// Pop/fired: take the root (S_POPS), fetch the last entry (S_FETCH, S_FETCHD), sift it down
// (S_WAIT); no fetch when the heap empties. Tick checks the root first (S_TCHK).
// One item at a time; per level a RAM read, then a compare; tick results come one by one.
// Reset (i_rst_n low, synchronous): count, state and valids cleared; heap RAM not cleared.
module timer_min_heap_core #(
    parameter int CAPACITY = tmh_pkg::CAP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tmh_pkg::FUNC_W-1:0]    i_func,
    input  logic [tmh_pkg::EXP_W-1:0]     i_expiry_time,
    input  logic [tmh_pkg::HDL_W-1:0]     i_timer_handle,
    input  logic [tmh_pkg::EXP_W-1:0]     i_current_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tmh_pkg::KIND_W-1:0]    o_kind,
    output logic [tmh_pkg::HDL_W-1:0]     o_out_handle,
    output logic [tmh_pkg::EXP_W-1:0]     o_out_expiry,
    output logic [$clog2(CAPACITY+1)-1:0] o_count_after,
    output logic [tmh_pkg::EXP_W-1:0]     o_earliest_expiry,
    output logic                          o_is_empty,
    output logic                          o_last
);

    import tmh_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NLEV = $clog2(CAPACITY + 1);
    localparam int RW   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TCHK,
        S_POPS,
        S_FETCH,
        S_FETCHD,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    t_entry            r_root;
    logic [EXP_W-1:0]  r_now;
    logic [KIND_W-1:0] r_kind;
    t_entry            r_res;
    logic [RW-1:0]     r_nres;
    t_tok              r_tok1;
    logic [IDX_W-1:0]  r_npath;
    logic [LVL_W-1:0]  r_tdep;
    logic [IDX_W-1:0]  r_fetch_row;
    logic [LVL_W-1:0]  r_fetch_lvl;
    logic              r_fetch_slot;

    logic              r_o_valid;
    logic [KIND_W-1:0] r_o_kind;
    t_entry            r_o_ent;
    logic [CW-1:0]     r_o_count;
    logic [EXP_W-1:0]  r_o_earliest;
    logic              r_o_last;

    t_tok             w_tok [1:NLEV];
    t_wb              w_wb  [1:NLEV];
    t_row             w_rows [1:NLEV-1];
    logic [NLEV-1:1]  w_done_vec;
    t_ctx             w_ctx;
    t_entry           w_fetch_ent;
    t_entry           w_new;
    logic             w_in_xfer;
    logic             w_oload;
    logic             w_more;
    logic [IDX_W-1:0] w_n;
    logic [IDX_W-1:0] w_cn;
    logic [IDX_W-1:0] w_m;
    logic [LVL_W-1:0] w_mlvl;
    logic [IDX_W-1:0] w_k;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_xfer = i_valid && o_ready;
    assign w_new     = '{exp: i_expiry_time, hdl: i_timer_handle};

    assign w_ctx = '{count: IDX_W'(r_count), npath: r_npath, tdep: r_tdep};

    assign w_tok[1]    = r_tok1;
    assign w_wb[NLEV]  = '0;

    for (genvar l = 1; l < NLEV; l++) begin : g_cell
        tmh_cell #(
            .LEVEL(l),
            .NLEV (NLEV)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[l]),
            .o_tok      (w_tok[l+1]),
            .i_wb       (w_wb[l+1]),
            .o_wb       (w_wb[l]),
            .i_fetch_row(r_fetch_row),
            .i_ctx      (w_ctx),
            .o_rdata    (w_rows[l]),
            .o_done     (w_done_vec[l])
        );
    end

    always_comb begin
        w_fetch_ent = w_rows[1][r_fetch_slot];
        for (int l = 1; l < NLEV; l++) begin
            if (r_fetch_lvl == LVL_W'(l)) begin
                w_fetch_ent = w_rows[l][r_fetch_slot];
            end
        end
    end

    // slot of the new entry on add, and of the last entry, which a removal moves to the root
    assign w_n    = IDX_W'(r_count) + 1'b1;
    assign w_cn   = IDX_W'(r_count) - 1'b1;
    assign w_m    = w_cn + 1'b1;
    assign w_mlvl = lvl_of(w_m);
    assign w_k    = w_m - (IDX_W'(1) << w_mlvl);

    assign w_oload = (r_state == S_EMIT) && (!r_o_valid || i_ready);
    assign w_more  = (r_kind == K_FIRED) && ((r_nres + 1'b1) < RW'(MAX_RESULTS))
                     && (r_count != '0) && (r_root.exp <= r_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_tok1.valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_tok1.valid <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_wb[1].valid) begin
                r_root <= w_wb[1].ent;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_now  <= i_current_time;
                        r_nres <= '0;
                        case (i_func)
                            FN_ADD: begin
                                if (r_count >= CW'(CAPACITY)) begin
                                    r_kind  <= K_FULL;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_kind  <= K_ADDED;
                                    r_count <= r_count + 1'b1;
                                    if (r_count == '0) begin
                                        r_root  <= w_new;
                                        r_state <= S_EMIT;
                                    end else begin
                                        r_npath       <= w_n;
                                        r_tdep        <= lvl_of(w_n);
                                        r_tok1.valid  <= 1'b1;
                                        r_tok1.op     <= OP_INS;
                                        r_tok1.j      <= '0;
                                        if (r_root.exp > i_expiry_time) begin
                                            r_root        <= w_new;
                                            r_tok1.ent    <= r_root;
                                            r_tok1.placed <= 1'b1;
                                        end else begin
                                            r_tok1.ent    <= w_new;
                                            r_tok1.placed <= 1'b0;
                                        end
                                        r_state <= S_WAIT;
                                    end
                                end
                            end
                            FN_TICK: begin
                                r_kind  <= K_FIRED;
                                r_state <= S_TCHK;
                            end
                            FN_POP: begin
                                if (r_count != '0) begin
                                    r_kind  <= K_POPPED;
                                    r_state <= S_POPS;
                                end else begin
                                    r_kind  <= K_NONE;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                                r_kind  <= K_NONE;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_TCHK: begin
                    if ((r_count != '0) && (r_root.exp <= r_now)) begin
                        r_state <= S_POPS;
                    end else begin
                        r_kind  <= K_NONE;
                        r_state <= S_EMIT;
                    end
                end
                S_POPS: begin
                    r_res        <= r_root;
                    r_count      <= r_count - 1'b1;
                    r_fetch_row  <= w_k >> 1;
                    r_fetch_lvl  <= w_mlvl;
                    r_fetch_slot <= w_k[0];
                    r_state      <= (r_count == CW'(1)) ? S_EMIT : S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_FETCHD;
                end
                S_FETCHD: begin
                    // last entry restarts from the root and sifts down
                    r_tok1.valid  <= 1'b1;
                    r_tok1.op     <= OP_SIFT;
                    r_tok1.j      <= '0;
                    r_tok1.ent    <= w_fetch_ent;
                    r_tok1.placed <= 1'b0;
                    r_state       <= S_WAIT;
                end
                S_WAIT: begin
                    if (|w_done_vec) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_oload) begin
                        r_o_valid    <= 1'b1;
                        r_o_kind     <= r_kind;
                        r_o_ent      <= ((r_kind == K_FIRED) || (r_kind == K_POPPED))
                                        ? r_res : '0;
                        r_o_count    <= r_count;
                        r_o_earliest <= (r_count != '0) ? r_root.exp : '0;
                        r_o_last     <= !w_more;
                        if (w_more) begin
                            r_nres  <= r_nres + 1'b1;
                            r_state <= S_POPS;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_out_handle      = r_o_ent.hdl;
    assign o_out_expiry      = r_o_ent.exp;
    assign o_count_after     = r_o_count;
    assign o_earliest_expiry = r_o_earliest;
    assign o_is_empty        = (r_o_count == '0);
    assign o_last            = r_o_last;

endmodule

>>> sv/tmh_ram.sv
`timescale 1ns / 1ps

module tmh_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tmh_cell.sv
`timescale 1ns / 1ps

module tmh_cell #(
    parameter int LEVEL = 1,
    parameter int NLEV  = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmh_pkg::t_tok               i_tok,
    output tmh_pkg::t_tok               o_tok,
    input  tmh_pkg::t_wb                i_wb,
    output tmh_pkg::t_wb                o_wb,
    input  logic [tmh_pkg::IDX_W-1:0]   i_fetch_row,
    input  tmh_pkg::t_ctx               i_ctx,
    output tmh_pkg::t_row               o_rdata,
    output logic                        o_done
);

    import tmh_pkg::*;

    localparam int  RAW   = (LEVEL > 1) ? LEVEL - 1 : 1;
    localparam int  DEPTH = 1 << RAW;
    localparam bit  LAST  = (LEVEL == NLEV - 1);
    localparam logic [IDX_W:0] BASE = (IDX_W + 1)'(1 << LEVEL);

    t_tok           r_tok;
    t_tok           r_out;
    t_row           r_row;
    logic [RAW-1:0] r_addr;
    logic           r_slot;

    t_tok           n_out;
    t_row           w_rdata;
    t_row           w_lrow;
    logic           w_lwe;
    logic [RAW-1:0] w_raddr;
    logic           w_we;
    logic [RAW-1:0] w_waddr;
    t_row           w_wdata;
    t_row           w_wbrow;

    logic [IDX_W:0]   w_gl;
    logic             w_lv;
    logic             w_rv;
    logic             w_c;
    t_entry           w_ch;
    logic [IDX_W-1:0] w_sh;
    logic             w_s;
    t_entry           w_node;

    // token read has priority; fetch only happens while no walk is running
    assign w_raddr = i_tok.valid ? i_tok.j[RAW-1:0] : i_fetch_row[RAW-1:0];

    assign w_gl = BASE + {r_tok.j, 1'b0};
    assign w_lv = (w_gl <= {1'b0, i_ctx.count});
    assign w_rv = ((w_gl + 1'b1) <= {1'b0, i_ctx.count});
    assign w_c  = w_rv && (w_rdata[1].exp < w_rdata[0].exp);
    assign w_ch = w_rdata[w_c];

    assign w_sh   = i_ctx.npath >> (i_ctx.tdep - LVL_W'(LEVEL));
    assign w_s    = w_sh[0];
    assign w_node = w_rdata[w_s];

    always_comb begin
        n_out  = '0;
        o_wb   = '0;
        o_done = 1'b0;
        w_lwe  = 1'b0;
        w_lrow = w_rdata;
        if (r_tok.valid) begin
            if (r_tok.op == OP_SIFT) begin
                if (!w_lv) begin
                    o_wb.valid = 1'b1;
                    o_wb.ent   = r_tok.ent;
                    o_done     = 1'b1;
                end else if (w_ch.exp < r_tok.ent.exp) begin
                    o_wb.valid = 1'b1;
                    o_wb.ent   = w_ch;
                    if (LAST) begin
                        w_lwe       = 1'b1;
                        w_lrow[w_c] = r_tok.ent;
                        o_done      = 1'b1;
                    end else begin
                        n_out.valid = 1'b1;
                        n_out.op    = OP_SIFT;
                        n_out.j     = {r_tok.j[IDX_W-2:0], w_c};
                        n_out.ent   = r_tok.ent;
                    end
                end else begin
                    o_wb.valid = 1'b1;
                    o_wb.ent   = r_tok.ent;
                    o_done     = 1'b1;
                end
            end else begin
                if (i_ctx.tdep == LVL_W'(LEVEL)) begin
                    w_lwe       = 1'b1;
                    w_lrow[w_s] = r_tok.ent;
                    o_done      = 1'b1;
                end else begin
                    n_out.valid = 1'b1;
                    n_out.op    = OP_INS;
                    n_out.j     = {r_tok.j[IDX_W-2:0], w_s};
                    // once placed, every node below on the path shifts down one level
                    if (r_tok.placed || (w_node.exp > r_tok.ent.exp)) begin
                        w_lwe        = 1'b1;
                        w_lrow[w_s]  = r_tok.ent;
                        n_out.ent    = w_node;
                        n_out.placed = 1'b1;
                    end else begin
                        n_out.ent    = r_tok.ent;
                        n_out.placed = r_tok.placed;
                    end
                end
            end
        end
    end

    always_comb begin
        w_wbrow         = r_row;
        w_wbrow[r_slot] = i_wb.ent;
    end

    assign w_we    = w_lwe | i_wb.valid;
    assign w_waddr = i_wb.valid ? r_addr : r_tok.j[RAW-1:0];
    assign w_wdata = i_wb.valid ? w_wbrow : w_lrow;

    tmh_ram #(
        .WIDTH(ROW_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_out <= n_out;
        end
        // keep the row a sift moved a child out of, for the write from below
        if (r_tok.valid) begin
            r_addr <= r_tok.j[RAW-1:0];
            r_row  <= w_rdata;
            r_slot <= w_c;
        end
    end

    assign o_tok   = r_out;
    assign o_rdata = w_rdata;

endmodule
